>>> hw/rtl/lav_pkg.sv
package lav_pkg;

    localparam int COORD_W = 32;
    localparam int D_W     = 33;
    localparam int C_W     = 51;
    localparam int MAG_W   = 30;
    localparam int NORM    = MAG_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int UNIT_W  = QUO_W + 1;
    localparam int UP_W    = UNIT_W + 1;
    localparam int RND_IN_W  = 56;
    localparam int RND_OUT_W = RND_IN_W - FRAC_W;
    localparam int COLS    = 4;

    localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;

    typedef logic signed [COORD_W-1:0] t_q16;
    typedef logic signed [UNIT_W-1:0] t_unit;
    typedef logic [COLS-1:0][COLS-1:0][COORD_W-1:0] t_mat;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } t_emit_ctl;

    function automatic logic signed [RND_OUT_W-1:0] round16(
        input logic signed [RND_IN_W-1:0] x
    );
        logic signed [RND_IN_W-1:0] y;
        y = x + 56'sd32768;
        return RND_OUT_W'(y >>> FRAC_W);
    endfunction

    function automatic t_q16 sat32(input logic signed [RND_OUT_W-1:0] x);
        t_q16 r;
        if (x > 40'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = COORD_W'(x);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/lav_isqrt.sv
module lav_isqrt #(
    parameter int N_W = 62,
    parameter int R_W = 31,
    parameter int P_W = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_n,
    input  logic [P_W-1:0] i_p,
    output logic           o_valid,
    output logic [R_W-1:0] o_root,
    output logic [P_W-1:0] o_p
);
    import lav_pkg::*;

    logic [N_W-1:0] r_n   [R_W];
    logic [N_W-1:0] r_res [R_W];
    logic [P_W-1:0] r_p   [R_W];
    logic [R_W-1:0] r_v;

    for (genvar s = 0; s < R_W; s++) begin : g_step
        localparam int K = R_W - 1 - s;
        localparam logic [N_W:0] BIT = (N_W + 1)'(1) << (2 * K);
        logic [N_W-1:0] s_n;
        logic [N_W-1:0] s_res;
        logic [P_W-1:0] s_p;
        logic           s_v;
        logic [N_W:0]   s_trial;
        if (s == 0) begin : g_first
            assign s_n   = i_n;
            assign s_res = '0;
            assign s_p   = i_p;
            assign s_v   = i_valid;
        end else begin : g_next
            assign s_n   = r_n[s-1];
            assign s_res = r_res[s-1];
            assign s_p   = r_p[s-1];
            assign s_v   = r_v[s-1];
        end
        assign s_trial = {1'b0, s_res} + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= s_v;
            end
            r_p[s] <= s_p;
            if ({1'b0, s_n} >= s_trial) begin
                r_n[s]   <= N_W'({1'b0, s_n} - s_trial);
                r_res[s] <= N_W'({1'b0, s_res >> 1} + BIT);
            end else begin
                r_n[s]   <= s_n;
                r_res[s] <= s_res >> 1;
            end
        end
    end

    assign o_valid = r_v[R_W-1];
    assign o_root  = r_res[R_W-1][R_W-1:0];
    assign o_p     = r_p[R_W-1];

endmodule

>>> hw/rtl/lav_unit.sv
module lav_unit #(
    parameter int IN_W = 33,
    parameter int SB_W = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [2:0][IN_W-1:0]                  i_v,
    input  logic [SB_W-1:0]                       i_sb,
    output logic                                  o_valid,
    output logic [2:0][lav_pkg::UNIT_W-1:0]       o_u,
    output logic                                  o_zero,
    output logic [SB_W-1:0]                       o_sb
);
    import lav_pkg::*;

    localparam int TOP_W = $clog2(IN_W);
    localparam int P_W   = 3 * MAG_W + 3 + 1 + SB_W;

    function automatic logic [TOP_W-1:0] lead_one(input logic [IN_W-1:0] x);
        logic [TOP_W-1:0] t;
        t = '0;
        for (int k = 0; k < IN_W; k++) begin
            if (x[k]) begin
                t = TOP_W'(k);
            end
        end
        return t;
    endfunction

    // magnitude and sign
    logic                   r0_v;
    logic [2:0][IN_W-1:0]   r0_mag;
    logic [2:0]             r0_neg;
    logic [SB_W-1:0]        r0_sb;
    // largest magnitude
    logic                   r1_v;
    logic [2:0][IN_W-1:0]   r1_mag;
    logic [2:0]             r1_neg;
    logic [IN_W-1:0]        r1_mx;
    logic [SB_W-1:0]        r1_sb;
    // top bit position
    logic                   r2_v;
    logic [2:0][IN_W-1:0]   r2_mag;
    logic [2:0]             r2_neg;
    logic [TOP_W-1:0]       r2_top;
    logic                   r2_zero;
    logic [SB_W-1:0]        r2_sb;
    // scaled magnitudes
    logic                   r3_v;
    logic [2:0][MAG_W-1:0]  r3_sm;
    logic [2:0]             r3_neg;
    logic                   r3_zero;
    logic [SB_W-1:0]        r3_sb;
    // squares
    logic                   r4_v;
    logic [2:0][MAG_W-1:0]  r4_sm;
    logic [2:0][SQ_W-1:0]   r4_sq;
    logic [2:0]             r4_neg;
    logic                   r4_zero;
    logic [SB_W-1:0]        r4_sb;
    // sum of squares
    logic                   r5_v;
    logic [SUM_W-1:0]       r5_sum;
    logic [P_W-1:0]         r5_p;

    logic                   w_rv;
    logic [ROOT_W-1:0]      w_root;
    logic [P_W-1:0]         w_rp;
    logic [2:0][MAG_W-1:0]  w_sm;
    logic [2:0]             w_neg;
    logic                   w_zero;
    logic [SB_W-1:0]        w_sb;

    // dividend set-up
    logic                   r6_v;
    logic [2:0][NUM_W-1:0]  r6_num;
    logic [ROOT_W-1:0]      r6_len;
    logic [2:0]             r6_neg;
    logic                   r6_zero;
    logic [SB_W-1:0]        r6_sb;

    logic [2:0][NUM_W-1:0]  r_rem [QUO_W];
    logic [2:0][QUO_W-1:0]  r_q   [QUO_W];
    logic [ROOT_W-1:0]      r_len [QUO_W];
    logic [2:0]             r_neg [QUO_W];
    logic [QUO_W-1:0]       r_z;
    logic [SB_W-1:0]        r_sb  [QUO_W];
    logic [QUO_W-1:0]       r_dv;

    logic                   r7_v;
    logic [2:0][UNIT_W-1:0] r7_u;
    logic                   r7_zero;
    logic [SB_W-1:0]        r7_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= w_rv;
            r7_v <= r_dv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_neg[i] <= i_v[i][IN_W-1];
            r0_mag[i] <= i_v[i][IN_W-1] ? (~i_v[i] + 1'b1) : i_v[i];
        end
        r0_sb <= i_sb;

        r1_mag <= r0_mag;
        r1_neg <= r0_neg;
        r1_sb  <= r0_sb;
        if (r0_mag[0] >= r0_mag[1] && r0_mag[0] >= r0_mag[2]) begin
            r1_mx <= r0_mag[0];
        end else if (r0_mag[1] >= r0_mag[2]) begin
            r1_mx <= r0_mag[1];
        end else begin
            r1_mx <= r0_mag[2];
        end

        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_sb   <= r1_sb;
        r2_top  <= lead_one(r1_mx);
        r2_zero <= (r1_mx == '0);

        for (int i = 0; i < 3; i++) begin
            if (r2_top >= TOP_W'(NORM)) begin
                r3_sm[i] <= MAG_W'(r2_mag[i] >> (r2_top - TOP_W'(NORM)));
            end else begin
                r3_sm[i] <= MAG_W'(r2_mag[i] << (TOP_W'(NORM) - r2_top));
            end
        end
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        r3_sb   <= r2_sb;

        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= SQ_W'(r3_sm[i]) * SQ_W'(r3_sm[i]);
        end
        r4_sm   <= r3_sm;
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_sb   <= r3_sb;

        r5_sum <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
        r5_p   <= {r4_sm, r4_neg, r4_zero, r4_sb};
    end

    lav_isqrt #(
        .N_W (SUM_W),
        .R_W (ROOT_W),
        .P_W (P_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_n     (r5_sum),
        .i_p     (r5_p),
        .o_valid (w_rv),
        .o_root  (w_root),
        .o_p     (w_rp)
    );

    assign {w_sm, w_neg, w_zero, w_sb} = w_rp;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_num[i] <= {1'b0, w_sm[i], {FRAC_W{1'b0}}} + NUM_W'(w_root >> 1);
        end
        r6_len  <= w_root;
        r6_neg  <= w_neg;
        r6_zero <= w_zero;
        r6_sb   <= w_sb;
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic [2:0][NUM_W-1:0] s_rem;
        logic [2:0][QUO_W-1:0] s_q;
        logic [ROOT_W-1:0]     s_len;
        logic [2:0]            s_neg;
        logic                  s_z;
        logic [SB_W-1:0]       s_sb;
        logic                  s_v;
        logic [NUM_W:0]        s_den;
        if (j == 0) begin : g_first
            assign s_rem = r6_num;
            assign s_q   = '0;
            assign s_len = r6_len;
            assign s_neg = r6_neg;
            assign s_z   = r6_zero;
            assign s_sb  = r6_sb;
            assign s_v   = r6_v;
        end else begin : g_next
            assign s_rem = r_rem[j-1];
            assign s_q   = r_q[j-1];
            assign s_len = r_len[j-1];
            assign s_neg = r_neg[j-1];
            assign s_z   = r_z[j-1];
            assign s_sb  = r_sb[j-1];
            assign s_v   = r_dv[j-1];
        end
        assign s_den = (NUM_W + 1)'(s_len) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else begin
                r_dv[j] <= s_v;
            end
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, s_rem[i]} >= s_den) begin
                    r_rem[j][i] <= NUM_W'({1'b0, s_rem[i]} - s_den);
                    r_q[j][i]   <= {s_q[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[j][i] <= s_rem[i];
                    r_q[j][i]   <= {s_q[i][QUO_W-2:0], 1'b0};
                end
            end
            r_len[j] <= s_len;
            r_neg[j] <= s_neg;
            r_z[j]   <= s_z;
            r_sb[j]  <= s_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_z[QUO_W-1]) begin
                r7_u[i] <= '0;
            end else if (r_neg[QUO_W-1][i]) begin
                r7_u[i] <= UNIT_W'(-{1'b0, r_q[QUO_W-1][i]});
            end else begin
                r7_u[i] <= {1'b0, r_q[QUO_W-1][i]};
            end
        end
        r7_zero <= r_z[QUO_W-1];
        r7_sb   <= r_sb[QUO_W-1];
    end

    assign o_valid = r7_v;
    assign o_u     = r7_u;
    assign o_zero  = r7_zero;
    assign o_sb    = r7_sb;

endmodule

>>> hw/rtl/lav_emit.sv
module lav_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lav_pkg::t_emit_ctl i_ctl,
    input  lav_pkg::t_mat      i_mat,
    output logic               o_strobe,
    output logic [1:0]         o_column_index,
    output lav_pkg::t_q16      o_row0,
    output lav_pkg::t_q16      o_row1,
    output lav_pkg::t_q16      o_row2,
    output lav_pkg::t_q16      o_row3,
    output logic               o_last_column,
    output logic               o_degenerate
);
    import lav_pkg::*;

    localparam logic [1:0] LAST = 2'(COLS - 1);

    logic       r_act;
    logic [1:0] r_idx;
    t_mat       r_mat;
    logic       r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
        end else if (i_ctl.valid) begin
            r_act <= 1'b1;
            r_idx <= '0;
        end else if (r_act) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_mat   <= i_mat;
            r_degen <= i_ctl.degenerate;
        end
    end

    assign o_strobe       = r_act;
    assign o_column_index = r_idx;
    assign o_row0         = r_mat[r_idx][0];
    assign o_row1         = r_mat[r_idx][1];
    assign o_row2         = r_mat[r_idx][2];
    assign o_row3         = r_mat[r_idx][3];
    assign o_last_column  = (r_idx == LAST);
    assign o_degenerate   = r_degen;

endmodule

>>> hw/rtl/look_at_view_matrix.sv
// channel   | handshake            | ports
// ----------+----------------------+----------------------------------------------
// camera in | start & !busy        | i_eye_*, i_target_*, i_up_*
// column out| o_strobe, per column | o_column_index, o_row0..3, o_last_column,
//           |                      | o_degenerate
//
// no new item is taken while busy is high; busy goes high after an accept and is held
// for the four result columns that share one output port.
// the columns of an item leave on consecutive cycles; most of the pipeline depth is the
// two square-root and divide chains, one bit a stage.
// synchronous active-low reset clears the valid bits, the busy counter and the column sequencer.
// results cannot be held off, so nothing in the pipeline ever stalls.
module look_at_view_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lav_pkg::t_q16 i_eye_x,
    input  lav_pkg::t_q16 i_eye_y,
    input  lav_pkg::t_q16 i_eye_z,
    input  lav_pkg::t_q16 i_target_x,
    input  lav_pkg::t_q16 i_target_y,
    input  lav_pkg::t_q16 i_target_z,
    input  lav_pkg::t_q16 i_up_x,
    input  lav_pkg::t_q16 i_up_y,
    input  lav_pkg::t_q16 i_up_z,
    output logic          o_strobe,
    output logic [1:0]    o_column_index,
    output lav_pkg::t_q16 o_row0,
    output lav_pkg::t_q16 o_row1,
    output lav_pkg::t_q16 o_row2,
    output lav_pkg::t_q16 o_row3,
    output logic          o_last_column,
    output logic          o_degenerate
);
    import lav_pkg::*;

    localparam int SB1_W = 6 * COORD_W;
    localparam int SB2_W = 3 * COORD_W + 3 * UNIT_W + 1;
    localparam logic [1:0] GAP = 2'(COLS - 1);

    logic [1:0] r_gap;
    logic       w_acc;

    assign w_acc = start && !busy;
    assign busy  = (r_gap != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (w_acc) begin
            r_gap <= GAP;
        end else if (busy) begin
            r_gap <= r_gap - 1'b1;
        end
    end

    // stage a: difference
    logic                   r_a_v;
    logic signed [D_W-1:0]  r_a_d  [3];
    t_q16                   r_a_eye[3];
    t_q16                   r_a_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= w_acc;
        end
        r_a_eye[0] <= i_eye_x;
        r_a_eye[1] <= i_eye_y;
        r_a_eye[2] <= i_eye_z;
        r_a_up[0]  <= i_up_x;
        r_a_up[1]  <= i_up_y;
        r_a_up[2]  <= i_up_z;
        r_a_d[0]   <= D_W'(i_target_x) - D_W'(i_eye_x);
        r_a_d[1]   <= D_W'(i_target_y) - D_W'(i_eye_y);
        r_a_d[2]   <= D_W'(i_target_z) - D_W'(i_eye_z);
    end

    logic                     w1_v;
    logic [2:0][UNIT_W-1:0]   w1_u;
    logic                     w1_zero;
    logic [SB1_W-1:0]         w1_sb;
    t_q16                     w1_eye[3];
    t_q16                     w1_up [3];
    t_unit                    w1_f  [3];

    lav_unit #(
        .IN_W (D_W),
        .SB_W (SB1_W)
    ) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .i_v     ({r_a_d[2], r_a_d[1], r_a_d[0]}),
        .i_sb    ({r_a_eye[2], r_a_eye[1], r_a_eye[0], r_a_up[2], r_a_up[1], r_a_up[0]}),
        .o_valid (w1_v),
        .o_u     (w1_u),
        .o_zero  (w1_zero),
        .o_sb    (w1_sb)
    );

    assign {w1_eye[2], w1_eye[1], w1_eye[0], w1_up[2], w1_up[1], w1_up[0]} = w1_sb;
    assign w1_f[0] = $signed(w1_u[0]);
    assign w1_f[1] = $signed(w1_u[1]);
    assign w1_f[2] = $signed(w1_u[2]);

    // stage c: forward times up hint
    logic                          r_c_v;
    logic signed [C_W-2:0]         r_c_p  [6];
    t_unit                         r_c_f  [3];
    t_q16                          r_c_eye[3];
    logic                          r_c_zf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= w1_v;
        end
        r_c_p[0] <= w1_f[1] * w1_up[2];
        r_c_p[1] <= w1_f[2] * w1_up[1];
        r_c_p[2] <= w1_f[2] * w1_up[0];
        r_c_p[3] <= w1_f[0] * w1_up[2];
        r_c_p[4] <= w1_f[0] * w1_up[1];
        r_c_p[5] <= w1_f[1] * w1_up[0];
        r_c_f    <= w1_f;
        r_c_eye  <= w1_eye;
        r_c_zf   <= w1_zero;
    end

    // stage d: cross product
    logic                    r_d_v;
    logic signed [C_W-1:0]   r_d_c  [3];
    t_unit                   r_d_f  [3];
    t_q16                    r_d_eye[3];
    logic                    r_d_zf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
        r_d_c[0] <= r_c_p[0] - r_c_p[1];
        r_d_c[1] <= r_c_p[2] - r_c_p[3];
        r_d_c[2] <= r_c_p[4] - r_c_p[5];
        r_d_f    <= r_c_f;
        r_d_eye  <= r_c_eye;
        r_d_zf   <= r_c_zf;
    end

    logic                   w2_v;
    logic [2:0][UNIT_W-1:0] w2_u;
    logic                   w2_zero;
    logic [SB2_W-1:0]       w2_sb;
    t_q16                   w2_eye[3];
    t_unit                  w2_f  [3];
    t_unit                  w2_r  [3];
    logic                   w2_zf;

    lav_unit #(
        .IN_W (C_W),
        .SB_W (SB2_W)
    ) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_v     ({r_d_c[2], r_d_c[1], r_d_c[0]}),
        .i_sb    ({r_d_eye[2], r_d_eye[1], r_d_eye[0],
                   r_d_f[2], r_d_f[1], r_d_f[0], r_d_zf}),
        .o_valid (w2_v),
        .o_u     (w2_u),
        .o_zero  (w2_zero),
        .o_sb    (w2_sb)
    );

    assign {w2_eye[2], w2_eye[1], w2_eye[0], w2_f[2], w2_f[1], w2_f[0], w2_zf} = w2_sb;
    assign w2_r[0] = $signed(w2_u[0]);
    assign w2_r[1] = $signed(w2_u[1]);
    assign w2_r[2] = $signed(w2_u[2]);

    // stage e: products for the new up vector and the dot products
    logic                          r_e_v;
    logic signed [2*UNIT_W-1:0]    r_e_rf [6];
    logic signed [UNIT_W+COORD_W-1:0] r_e_re[3];
    logic signed [UNIT_W+COORD_W-1:0] r_e_fe[3];
    t_unit                         r_e_r  [3];
    t_unit                         r_e_f  [3];
    t_q16                          r_e_eye[3];
    logic                          r_e_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= w2_v;
        end
        r_e_rf[0] <= w2_r[1] * w2_f[2];
        r_e_rf[1] <= w2_r[2] * w2_f[1];
        r_e_rf[2] <= w2_r[2] * w2_f[0];
        r_e_rf[3] <= w2_r[0] * w2_f[2];
        r_e_rf[4] <= w2_r[0] * w2_f[1];
        r_e_rf[5] <= w2_r[1] * w2_f[0];
        for (int i = 0; i < 3; i++) begin
            r_e_re[i] <= w2_r[i] * w2_eye[i];
            r_e_fe[i] <= w2_f[i] * w2_eye[i];
        end
        r_e_r   <= w2_r;
        r_e_f   <= w2_f;
        r_e_eye <= w2_eye;
        r_e_ok  <= !w2_zf && !w2_zero;
    end

    // stage f: up vector, forward and right dot products
    logic                          r_f_v;
    logic signed [UP_W-1:0]        r_f_u  [3];
    logic signed [UNIT_W+COORD_W+1:0] r_f_dr;
    logic signed [UNIT_W+COORD_W+1:0] r_f_df;
    t_unit                         r_f_r  [3];
    t_unit                         r_f_f  [3];
    t_q16                          r_f_eye[3];
    logic                          r_f_ok;
    logic signed [RND_IN_W-1:0]    w_f_x  [3];

    always_comb begin
        w_f_x[0] = r_e_rf[0] - r_e_rf[1];
        w_f_x[1] = r_e_rf[2] - r_e_rf[3];
        w_f_x[2] = r_e_rf[4] - r_e_rf[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
        for (int i = 0; i < 3; i++) begin
            r_f_u[i] <= UP_W'(round16(w_f_x[i]));
        end
        r_f_dr  <= r_e_re[0] + r_e_re[1] + r_e_re[2];
        r_f_df  <= r_e_fe[0] + r_e_fe[1] + r_e_fe[2];
        r_f_r   <= r_e_r;
        r_f_f   <= r_e_f;
        r_f_eye <= r_e_eye;
        r_f_ok  <= r_e_ok;
    end

    // stage g: up times eye
    logic                          r_g_v;
    logic signed [UP_W+COORD_W-1:0] r_g_ue[3];
    logic signed [UP_W-1:0]        r_g_u  [3];
    logic signed [UNIT_W+COORD_W+1:0] r_g_dr;
    logic signed [UNIT_W+COORD_W+1:0] r_g_df;
    t_unit                         r_g_r  [3];
    t_unit                         r_g_f  [3];
    logic                          r_g_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
        for (int i = 0; i < 3; i++) begin
            r_g_ue[i] <= r_f_u[i] * r_f_eye[i];
        end
        r_g_u  <= r_f_u;
        r_g_dr <= r_f_dr;
        r_g_df <= r_f_df;
        r_g_r  <= r_f_r;
        r_g_f  <= r_f_f;
        r_g_ok <= r_f_ok;
    end

    // stage h: translation, right and forward terms
    logic                          r_h_v;
    logic signed [UP_W+COORD_W+1:0] r_h_du;
    t_q16                          r_h_t0;
    t_q16                          r_h_t2;
    logic signed [UP_W-1:0]        r_h_u  [3];
    t_unit                         r_h_r  [3];
    t_unit                         r_h_f  [3];
    logic                          r_h_ok;
    logic signed [RND_IN_W-1:0]    w_h_ndr;
    logic signed [RND_IN_W-1:0]    w_h_df;

    always_comb begin
        w_h_ndr = -r_g_dr;
        w_h_df  = r_g_df;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else begin
            r_h_v <= r_g_v;
        end
        r_h_du <= r_g_ue[0] + r_g_ue[1] + r_g_ue[2];
        r_h_t0 <= sat32(round16(w_h_ndr));
        r_h_t2 <= sat32(round16(w_h_df));
        r_h_u  <= r_g_u;
        r_h_r  <= r_g_r;
        r_h_f  <= r_g_f;
        r_h_ok <= r_g_ok;
    end

    // matrix assembly
    logic signed [RND_IN_W-1:0] w_i_ndu;
    t_q16                       w_i_t1;
    t_mat                       w_mat;
    t_emit_ctl                  w_ctl;

    always_comb begin
        w_i_ndu = -r_h_du;
        w_i_t1  = sat32(round16(w_i_ndu));
        w_mat   = '0;
        w_mat[3][3] = ONE_Q16;
        if (r_h_ok) begin
            for (int k = 0; k < 3; k++) begin
                w_mat[k][0] = COORD_W'(r_h_r[k]);
                w_mat[k][1] = COORD_W'(r_h_u[k]);
                w_mat[k][2] = COORD_W'(-r_h_f[k]);
            end
            w_mat[3][0] = r_h_t0;
            w_mat[3][1] = w_i_t1;
            w_mat[3][2] = r_h_t2;
        end
        w_ctl.valid      = r_h_v;
        w_ctl.degenerate = !r_h_ok;
    end

    lav_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_mat          (w_mat),
        .o_strobe       (o_strobe),
        .o_column_index (o_column_index),
        .o_row0         (o_row0),
        .o_row1         (o_row1),
        .o_row2         (o_row2),
        .o_row3         (o_row3),
        .o_last_column  (o_last_column),
        .o_degenerate   (o_degenerate)
    );

endmodule

>>> hw/rtl/lav_check.sv
module lav_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input lav_pkg::t_q16 i_eye_x,
    input lav_pkg::t_q16 i_eye_y,
    input lav_pkg::t_q16 i_eye_z,
    input lav_pkg::t_q16 i_target_x,
    input lav_pkg::t_q16 i_target_y,
    input lav_pkg::t_q16 i_target_z,
    input lav_pkg::t_q16 i_up_x,
    input lav_pkg::t_q16 i_up_y,
    input lav_pkg::t_q16 i_up_z,
    input logic          o_strobe,
    input logic [1:0]    o_column_index,
    input lav_pkg::t_q16 o_row0,
    input lav_pkg::t_q16 o_row1,
    input lav_pkg::t_q16 o_row2,
    input lav_pkg::t_q16 o_row3,
    input logic          o_last_column,
    input logic          o_degenerate
);
    import lav_pkg::*;

    // an accepted item blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted item");

    // columns of one item come on back-to-back cycles in order
    a_column_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_column_index != 2'd3 |=>
            o_strobe && o_column_index == 2'($past(o_column_index) + 2'd1))
        else $error("column sequence broken");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last_column == (o_column_index == 2'd3)))
        else $error("last column flag mismatch");

    a_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_column_index == 2'd3 ? o_row3 == ONE_Q16 : o_row3 == '0))
        else $error("bottom row of matrix wrong");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_degenerate |-> o_row0 == '0 && o_row1 == '0 && o_row2 == '0)
        else $error("degenerate item carries non-zero entries");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);
